// ===== src/ltb_pkg.sv =====
// ----------------------------------------------------------------------------
// ltb_pkg
// Shared types and constants of the plane-partition heat-bath update block.
// ----------------------------------------------------------------------------
package ltb_pkg;

	localparam int MAX_COLS   = 64;
	localparam int MAX_ROWS   = 64;
	localparam int VALUE_BITS = 16;

	localparam int FIELD_W   = 16;
	localparam int FRAC_W    = 16;
	localparam int FUNC_W    = 2;
	localparam int COORD_W   = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam int ROW_IW = $clog2(MAX_ROWS);
	localparam int COL_IW = $clog2(MAX_COLS);
	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PROD_W = FRAC_W + VALUE_BITS + 1;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [COORD_W-1:0]    coord_t;
	typedef logic [FUNC_W-1:0]     func_t;
	typedef logic [ROW_IW-1:0]     row_idx_t;
	typedef logic [COL_IW-1:0]     col_idx_t;

	localparam func_t FN_LOAD     = 2'd0;
	localparam func_t FN_RESAMPLE = 2'd1;
	localparam func_t FN_READ     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TOP_VALUE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_LEFT,
		ST_RD_ABOVE,
		ST_RD_RIGHT,
		ST_RD_BELOW,
		ST_CAP_BELOW,
		ST_MUL,
		ST_SUM,
		ST_RD_CENTER,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		AS_CENTER,
		AS_LEFT,
		AS_ABOVE,
		AS_RIGHT,
		AS_BELOW
	} addr_sel_t;

	typedef enum logic [1:0] {
		NB_LEFT,
		NB_ABOVE,
		NB_RIGHT,
		NB_BELOW
	} nb_t;

	// item info seen by the sequencer at the accepting edge
	typedef struct packed {
		logic  start;
		logic  range_err;
		func_t func;
	} req_t;

	// sequencer to datapath control
	typedef struct packed {
		logic      cmd_ready;
		logic      ram_re;
		logic      ram_we;
		addr_sel_t addr_sel;
		logic      cap_en;
		nb_t       cap_sel;
		logic      mul_en;
		logic      sum_en;
		logic      deliver;
	} ctl_t;

	typedef struct packed {
		logic first_row;
		logic first_col;
		logic last_row;
		logic last_col;
	} edge_t;

endpackage

// ===== src/ltb_if.sv =====
// ----------------------------------------------------------------------------
// ltb_if
// Valid/ready channels of the heat-bath block: command, response, config.
// ----------------------------------------------------------------------------
interface ltb_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [ltb_pkg::FUNC_W-1:0]         func;
	logic [ltb_pkg::COORD_W-1:0]        row;
	logic [ltb_pkg::COORD_W-1:0]        col;
	logic [ltb_pkg::FIELD_W-1:0]        cell_value;
	logic [ltb_pkg::FRAC_W-1:0]         random_fraction;

	modport source (output valid, func, row, col, cell_value, random_fraction, input ready);
	modport sink   (input valid, func, row, col, cell_value, random_fraction, output ready);
endinterface

interface ltb_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ltb_pkg::FIELD_W-1:0] value;
	logic                        range_error;

	modport source (output valid, value, range_error, input ready);
	modport sink   (input valid, value, range_error, output ready);
endinterface

interface ltb_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ltb_pkg::CFG_IDX_W-1:0] index;
	logic [ltb_pkg::CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/lozenge_tableau_heat_bath_top.sv =====
// ----------------------------------------------------------------------------
// lozenge_tableau_heat_bath_top
// Plane-partition height grid with load, read and heat-bath resample items.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  : one transfer per item (func, row, col, cell_value, random_fraction).
//   rsp  : one transfer per item (value, range_error), in command order.
//   cfg  : register writes (0 top_value, 1 cols_used, 2 rows_used), always
//          ready; write only while no item is in flight.
// Steps from the accepting edge to the result in the output register:
//   out-of-range or load goes straight to done; read does one registered
//   grid read; resample reads the neighbors from the single grid memory
//   port, one per cycle, then captures the last, multiplies and adds. cmd is
//   ready again in the cycle the result shows on rsp; write-back is in done.
// One item is worked at a time. A registered result may wait for rsp.ready
// while the next item is accepted; that item then holds in its last step
// until the output register frees up.
// Reset clears the sequencer, the output valid and the registers (top_value 0,
// sizes 64). Grid contents are undefined until each cell is loaded.
// ----------------------------------------------------------------------------
module lozenge_tableau_heat_bath_top (
	input logic   clk,
	input logic   arst_n,
	ltb_cmd_if.sink   cmd,
	ltb_rsp_if.source rsp,
	ltb_cfg_if.sink   cfg
);
	import ltb_pkg::*;

	value_t   top_value_q;
	coord_t   cols_used_q;
	coord_t   rows_used_q;
	coord_t   nc;
	coord_t   nr;
	logic     range_err;
	logic     accept;
	req_t     req;
	ctl_t     ctl;
	row_idx_t rowm1_q;
	col_idx_t colm1_q;
	row_idx_t r_sel;
	col_idx_t c_sel;
	edge_t    edges_q;
	func_t    func_q;
	logic     err_q;
	value_t   cval_q;
	logic [FRAC_W-1:0] frac_q;
	addr_t    addr;
	value_t   rdata;
	value_t   calc;
	value_t   wdata;
	value_t   res_val;
	logic     out_free;
	logic     rsp_valid_q;
	value_t   rsp_value_q;
	logic     rsp_err_q;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_value_q <= '0;
			cols_used_q <= COORD_W'(MAX_COLS);
			rows_used_q <= COORD_W'(MAX_ROWS);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_TOP_VALUE: top_value_q <= value_t'(cfg.data);
				CFG_COLS_USED: cols_used_q <= cfg.data[COORD_W-1:0];
				CFG_ROWS_USED: rows_used_q <= cfg.data[COORD_W-1:0];
				default:       top_value_q <= top_value_q;
			endcase
		end
	end

	always_comb begin
		nc = cols_used_q;
		if (cols_used_q == '0) nc = COORD_W'(1);
		else if (cols_used_q > COORD_W'(MAX_COLS)) nc = COORD_W'(MAX_COLS);
		nr = rows_used_q;
		if (rows_used_q == '0) nr = COORD_W'(1);
		else if (rows_used_q > COORD_W'(MAX_ROWS)) nr = COORD_W'(MAX_ROWS);
	end

	assign range_err = (cmd.row == '0) || (cmd.row > nr) || (cmd.col == '0) || (cmd.col > nc);
	assign cmd.ready = ctl.cmd_ready;
	assign accept    = cmd.valid && ctl.cmd_ready;

	assign req.start     = accept;
	assign req.range_err = range_err;
	assign req.func      = cmd.func;

	// item registers
	always_ff @(posedge clk) begin
		if (accept) begin
			rowm1_q           <= row_idx_t'(cmd.row - COORD_W'(1));
			colm1_q           <= col_idx_t'(cmd.col - COORD_W'(1));
			edges_q.first_row <= cmd.row == COORD_W'(1);
			edges_q.first_col <= cmd.col == COORD_W'(1);
			edges_q.last_row  <= cmd.row == nr;
			edges_q.last_col  <= cmd.col == nc;
			func_q            <= cmd.func;
			err_q             <= range_err;
			cval_q            <= value_t'(cmd.cell_value);
			frac_q            <= cmd.random_fraction;
		end
	end

	always_comb begin
		r_sel = rowm1_q;
		c_sel = colm1_q;
		unique case (ctl.addr_sel)
			AS_LEFT:  c_sel = colm1_q - COL_IW'(1);
			AS_ABOVE: r_sel = rowm1_q - ROW_IW'(1);
			AS_RIGHT: c_sel = colm1_q + COL_IW'(1);
			AS_BELOW: r_sel = rowm1_q + ROW_IW'(1);
			default:  c_sel = colm1_q;
		endcase
	end

	assign addr = ADDR_W'(r_sel) * ADDR_W'(MAX_COLS) + ADDR_W'(c_sel);

	ltb_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.out_free (out_free),
		.ctl      (ctl)
	);

	ltb_bound_unit u_bound (
		.clk       (clk),
		.ctl       (ctl),
		.edges     (edges_q),
		.top_value (top_value_q),
		.frac      (frac_q),
		.rdata     (rdata),
		.result    (calc)
	);

	assign wdata = (func_q == FN_LOAD) ? cval_q : calc;

	ltb_grid_ram u_ram (
		.clk   (clk),
		.we    (ctl.ram_we),
		.re    (ctl.ram_re),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	always_comb begin
		if (err_q) begin
			res_val = '0;
		end else begin
			case (func_q)
				FN_LOAD:     res_val = cval_q;
				FN_RESAMPLE: res_val = calc;
				default:     res_val = rdata;
			endcase
		end
	end

	// output register
	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.deliver) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.deliver) begin
			rsp_value_q <= res_val;
			rsp_err_q   <= err_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.value       = FIELD_W'(rsp_value_q);
	assign rsp.range_error = rsp_err_q;

endmodule

// ===== src/ltb_grid_ram.sv =====
// ----------------------------------------------------------------------------
// ltb_grid_ram
// Single-port height grid memory with registered read data.
// ----------------------------------------------------------------------------
module ltb_grid_ram (
	input  logic           clk,
	input  logic           we,
	input  logic           re,
	input  ltb_pkg::addr_t addr,
	input  ltb_pkg::value_t wdata,
	output ltb_pkg::value_t rdata
);
	import ltb_pkg::*;

	value_t mem_q [DEPTH];
	value_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/ltb_bound_unit.sv =====
// ----------------------------------------------------------------------------
// ltb_bound_unit
// Shared compare unit folding neighbors into bounds, then scaled draw.
// ----------------------------------------------------------------------------
module ltb_bound_unit (
	input  logic                          clk,
	input  ltb_pkg::ctl_t                 ctl,
	input  ltb_pkg::edge_t                edges,
	input  ltb_pkg::value_t               top_value,
	input  logic [ltb_pkg::FRAC_W-1:0]    frac,
	input  ltb_pkg::value_t               rdata,
	output ltb_pkg::value_t               result
);
	import ltb_pkg::*;

	value_t              upper_q;
	value_t              lower_q;
	value_t              result_q;
	logic                empty_q;
	logic [PROD_W-1:0]   prod_q;
	value_t              nb_val;
	value_t              acc;
	logic                lt;
	logic [VALUE_BITS:0] span;

	always_comb begin
		nb_val = rdata;
		acc    = upper_q;
		case (ctl.cap_sel)
			NB_LEFT:  if (edges.first_col) nb_val = top_value;
			NB_ABOVE: if (edges.first_row) nb_val = top_value;
			NB_RIGHT: begin
				acc = lower_q;
				if (edges.last_col) nb_val = '0;
			end
			NB_BELOW: begin
				acc = lower_q;
				if (edges.last_row) nb_val = '0;
			end
			default: acc = upper_q;
		endcase
	end

	assign lt   = nb_val < acc;
	assign span = {1'b0, upper_q} - {1'b0, lower_q} + (VALUE_BITS+1)'(1);

	always_ff @(posedge clk) begin
		if (ctl.cap_en) begin
			case (ctl.cap_sel)
				NB_LEFT:  upper_q <= nb_val;
				NB_ABOVE: upper_q <= lt ? nb_val : upper_q;
				NB_RIGHT: lower_q <= nb_val;
				NB_BELOW: lower_q <= lt ? lower_q : nb_val;
				default:  lower_q <= lower_q;
			endcase
		end
		if (ctl.mul_en) begin
			empty_q <= upper_q < lower_q;
			prod_q  <= PROD_W'(frac) * PROD_W'(span);
		end
		if (ctl.sum_en) begin
			result_q <= empty_q ? lower_q : lower_q + prod_q[FRAC_W +: VALUE_BITS];
		end
	end

	assign result = result_q;

endmodule

// ===== src/ltb_seq.sv =====
// ----------------------------------------------------------------------------
// ltb_seq
// Sequencer: steps one item through grid reads, bound folding and write-back.
// ----------------------------------------------------------------------------
module ltb_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  ltb_pkg::req_t req,
	input  logic          out_free,
	output ltb_pkg::ctl_t ctl
);
	import ltb_pkg::*;

	state_t state_q;
	state_t state_d;
	func_t  func_q;
	logic   err_q;
	logic   writes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			func_q  <= FN_READ;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req.start) begin
				func_q <= req.func;
				err_q  <= req.range_err;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.start) begin
					if (req.range_err) begin
						state_d = ST_DONE;
					end else begin
						case (req.func)
							FN_LOAD:     state_d = ST_DONE;
							FN_RESAMPLE: state_d = ST_RD_LEFT;
							default:     state_d = ST_RD_CENTER;
						endcase
					end
				end
			end
			ST_RD_LEFT:   state_d = ST_RD_ABOVE;
			ST_RD_ABOVE:  state_d = ST_RD_RIGHT;
			ST_RD_RIGHT:  state_d = ST_RD_BELOW;
			ST_RD_BELOW:  state_d = ST_CAP_BELOW;
			ST_CAP_BELOW: state_d = ST_MUL;
			ST_MUL:       state_d = ST_SUM;
			ST_SUM:       state_d = ST_DONE;
			ST_RD_CENTER: state_d = ST_DONE;
			ST_DONE:      if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	assign writes = !err_q && (func_q == FN_LOAD || func_q == FN_RESAMPLE);

	always_comb begin
		ctl = '0;
		ctl.addr_sel = AS_CENTER;
		ctl.cap_sel  = NB_LEFT;
		unique case (state_q)
			ST_IDLE:      ctl.cmd_ready = 1'b1;
			ST_RD_LEFT: begin
				ctl.ram_re   = 1'b1;
				ctl.addr_sel = AS_LEFT;
			end
			ST_RD_ABOVE: begin
				ctl.ram_re   = 1'b1;
				ctl.addr_sel = AS_ABOVE;
				ctl.cap_en   = 1'b1;
				ctl.cap_sel  = NB_LEFT;
			end
			ST_RD_RIGHT: begin
				ctl.ram_re   = 1'b1;
				ctl.addr_sel = AS_RIGHT;
				ctl.cap_en   = 1'b1;
				ctl.cap_sel  = NB_ABOVE;
			end
			ST_RD_BELOW: begin
				ctl.ram_re   = 1'b1;
				ctl.addr_sel = AS_BELOW;
				ctl.cap_en   = 1'b1;
				ctl.cap_sel  = NB_RIGHT;
			end
			ST_CAP_BELOW: begin
				ctl.cap_en  = 1'b1;
				ctl.cap_sel = NB_BELOW;
			end
			ST_MUL:       ctl.mul_en = 1'b1;
			ST_SUM:       ctl.sum_en = 1'b1;
			ST_RD_CENTER: ctl.ram_re = 1'b1;
			ST_DONE: begin
				ctl.deliver = out_free;
				ctl.ram_we  = out_free && writes;
			end
			default:      ctl.cmd_ready = 1'b0;
		endcase
	end

endmodule
